// ===== hw/rtl/mpd_pkg.sv =====
// Shared types and constants for the mouse packet decoder.
// Used by the assembler, the event memory and the top level.
`timescale 1ns / 1ps

package mpd_pkg;

  localparam int ENTRY_W = 19;

  // Input kinds carried in bit 0 of the input tuser.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Bits of the first packet byte.
  localparam logic [7:0] SYNC_BIT    = 8'h08;
  localparam logic [7:0] X_OVERFLOW  = 8'h40;
  localparam logic [7:0] Y_OVERFLOW  = 8'h80;
  localparam logic [7:0] BUTTON_MASK = 8'h07;

  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } byte_pos_t;

  // A decoded event offered to the FIFO.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

endpackage

// ===== hw/rtl/mouse_packet_decoder_fifo.sv =====
// Mouse packet decoder: byte assembly, event FIFO pointers, output stage.
// Depends on mpd_pkg, mpd_assembler and mpd_event_mem.
// A result word passes through the event memory read register and then the
// output register, each of which holds its word while the output stalls.
// One word is accepted per cycle while the output is not stalled.
// Reset clears the packet position, FIFO pointers and pipeline valids;
// the event memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module mouse_packet_decoder_fifo
  import mpd_pkg::*;
#(
  parameter int FIFO_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [0] op, [1] from_aux
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] delta_x, [16:8] delta_y, [19:17] buttons,
                                      // [20] events_waiting, [23:21] zero
  output logic        m_axis_tuser    // [0] event_valid
);

  localparam int ADDR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FIFO_DEPTH - 1);

  logic              s_accept;
  logic              is_pop;
  logic              byte_en;
  push_t             push;
  logic [ADDR_W-1:0] wp, wp_next, wp_inc;
  logic [ADDR_W-1:0] rp, rp_next, rp_inc;
  logic              not_empty;
  logic              full;
  logic              do_push;
  logic              do_pop;
  entry_t            rd_entry;

  logic              s1_valid;
  logic              s1_hit;
  logic              s1_waiting;
  logic              s1_move;
  logic              out_valid;

  logic [7:0]        dx_calc;
  logic [8:0]        dy_calc;
  logic [2:0]        btn_calc;

  assign s1_move       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || !out_valid || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign is_pop        = (s_axis_tuser[0] == OP_POP);
  assign byte_en       = s_accept && !is_pop && s_axis_tuser[1];

  mpd_assembler u_asm (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (byte_en),
    .data_byte (s_axis_tdata),
    .push      (push)
  );

  assign wp_inc    = (wp == LAST_ADDR) ? '0 : wp + ADDR_W'(1);
  assign rp_inc    = (rp == LAST_ADDR) ? '0 : rp + ADDR_W'(1);
  assign not_empty = (wp != rp);
  assign full      = (wp_inc == rp);
  assign do_push   = push.valid && !full;
  assign do_pop    = s_accept && is_pop && not_empty;
  assign wp_next   = do_push ? wp_inc : wp;
  assign rp_next   = do_pop ? rp_inc : rp;

  // A pop only reads entries written at an earlier edge, so the
  // registered read never races the write port.
  mpd_event_mem #(
    .DEPTH  (FIFO_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (do_push),
    .waddr (wp),
    .wdata (push.entry),
    .re    (s_accept),
    .raddr (rp),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      s1_valid <= 1'b0;
    end else begin
      wp <= wp_next;
      rp <= rp_next;
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_hit     <= do_pop;
      s1_waiting <= (wp_next != rp_next);
    end
  end

  // Byte 2 is stored raw; the vertical delta is its negation, 9 bits wide.
  always_comb begin
    dx_calc  = s1_hit ? rd_entry[10:3] : 8'h00;
    dy_calc  = s1_hit ? (9'd0 - {rd_entry[18], rd_entry[18:11]}) : 9'd0;
    btn_calc = s1_hit ? rd_entry[2:0] : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_axis_tuser <= s1_hit;
      m_axis_tdata <= {3'b000, s1_waiting, btn_calc, dy_calc, dx_calc};
    end
  end

  assign m_axis_tvalid = out_valid;

  a_rp_only_on_pop: assert property (@(posedge clk) disable iff (rst)
    !do_pop |=> $stable(rp))
    else $error("read pointer moved without a pop");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (push.valid && full) |=> $stable(wp))
    else $error("write pointer moved on a full FIFO");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> s1_valid)
    else $error("stage result lost while output stalled");

  a_no_hit_when_empty: assert property (@(posedge clk) disable iff (rst)
    (s_accept && is_pop && !not_empty) |=> !s1_hit)
    else $error("empty pop flagged as an event");

endmodule

// ===== hw/rtl/mpd_assembler.sv =====
// Collects three-byte mouse packets and emits one FIFO push per good packet.
// Depends on mpd_pkg.
`timescale 1ns / 1ps

module mpd_assembler
  import mpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_en,
  input  logic [7:0] data_byte,
  output push_t      push
);

  byte_pos_t  pos;
  byte_pos_t  pos_next;
  logic [7:0] byte0;
  logic [7:0] byte1;

  always_comb begin
    pos_next   = pos;
    push.valid = 1'b0;
    push.entry = {data_byte, byte1, byte0[2:0]};
    if (byte_en) begin
      unique case (pos)
        POS_FIRST: begin
          if ((data_byte & SYNC_BIT) != 8'h00) pos_next = POS_SECOND;
        end
        POS_SECOND: pos_next = POS_THIRD;
        POS_THIRD: begin
          pos_next   = POS_FIRST;
          push.valid = ((byte0 & (X_OVERFLOW | Y_OVERFLOW)) == 8'h00);
        end
        default: pos_next = POS_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_FIRST;
    end else begin
      pos <= pos_next;
    end
  end

  // Packet bytes are always written before they are used.
  always_ff @(posedge clk) begin
    if (byte_en && pos == POS_FIRST) byte0 <= data_byte & (BUTTON_MASK | ~BUTTON_MASK);
    if (byte_en && pos == POS_SECOND) byte1 <= data_byte;
  end

endmodule

// ===== hw/rtl/mpd_event_mem.sv =====
// Event store: one write port, one read port with registered read data.
// Depends on mpd_pkg.
`timescale 1ns / 1ps

module mpd_event_mem
  import mpd_pkg::*;
#(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
